// ===== design/lpc_pkg.sv =====
// Shared types, codes and helpers for the link provisioning controller.
package lpc_pkg;

    localparam int unsigned EventWidth  = 4;
    localparam int unsigned ActionWidth = 8;
    localparam int unsigned StateWidth  = 4;
    localparam int unsigned CountWidth  = 8;

    localparam logic [CountWidth-1:0] RetryCountMax    = 8'hFF;
    localparam logic [CountWidth-1:0] MaxRetriesReset  = 8'd5;

    // Action mask bits.
    localparam logic [ActionWidth-1:0] ACT_NONE     = 8'h00;
    localparam logic [ActionWidth-1:0] ACT_CONNECT  = 8'h01;
    localparam logic [ActionWidth-1:0] ACT_OPEN     = 8'h02;
    localparam logic [ActionWidth-1:0] ACT_CLOSE    = 8'h04;
    localparam logic [ActionWidth-1:0] ACT_ONLINE   = 8'h08;
    localparam logic [ActionWidth-1:0] ACT_RESTORE  = 8'h10;
    localparam logic [ActionWidth-1:0] ACT_PERSIST  = 8'h20;
    localparam logic [ActionWidth-1:0] ACT_VERIFY   = 8'h40;
    localparam logic [ActionWidth-1:0] ACT_ROLLBACK = 8'h80;

    typedef enum logic [EventWidth-1:0] {
        EV_BOOT_SAVED   = 4'd0,
        EV_BOOT_NOSAVED = 4'd1,
        EV_GOT_IP       = 4'd2,
        EV_DISCONNECTED = 4'd3,
        EV_RETRY        = 4'd4,
        EV_RECONFIGURE  = 4'd5,
        EV_SUBMITTED    = 4'd6,
        EV_PROV_FAIL    = 4'd7,
        EV_CAND_IP      = 4'd8,
        EV_COMMIT_OK    = 4'd9,
        EV_COMMIT_FAIL  = 4'd10,
        EV_VERIFY_IP    = 4'd11,
        EV_VERIFY_FAIL  = 4'd12,
        EV_RB_OK        = 4'd13,
        EV_RB_FAIL      = 4'd14,
        EV_ABORTED      = 4'd15
    } t_event;

    typedef enum logic [9:0] {
        ST_BOOT       = 10'b00_0000_0001,
        ST_CONN_SAVED = 10'b00_0000_0010,
        ST_SAVED_FAIL = 10'b00_0000_0100,
        ST_PROV       = 10'b00_0000_1000,
        ST_CONN_CAND  = 10'b00_0001_0000,
        ST_PERSIST    = 10'b00_0010_0000,
        ST_VERIFY     = 10'b00_0100_0000,
        ST_ROLLBACK   = 10'b00_1000_0000,
        ST_CAND_FAIL  = 10'b01_0000_0000,
        ST_ONLINE     = 10'b10_0000_0000
    } t_link_state;

    typedef struct packed {
        t_link_state           link_state;
        logic                  saved;
        logic                  candidate;
        logic [CountWidth-1:0] retries;
    } t_lpc_status;

    // Binary state number as reported on the result channel.
    function automatic logic [StateWidth-1:0] state_number(input t_link_state st);
        logic [StateWidth-1:0] num;
        case (st)
            ST_BOOT:       num = 4'd0;
            ST_CONN_SAVED: num = 4'd1;
            ST_SAVED_FAIL: num = 4'd2;
            ST_PROV:       num = 4'd3;
            ST_CONN_CAND:  num = 4'd4;
            ST_PERSIST:    num = 4'd5;
            ST_VERIFY:     num = 4'd6;
            ST_ROLLBACK:   num = 4'd7;
            ST_CAND_FAIL:  num = 4'd8;
            ST_ONLINE:     num = 4'd9;
            default:       num = 4'd0;
        endcase
        return num;
    endfunction

endpackage

// ===== design/lpc_next_state.sv =====
// Next-status and action decode for one event.
module lpc_next_state (
    input  lpc_pkg::t_lpc_status            i_status,
    input  lpc_pkg::t_event                 i_event,
    input  logic [lpc_pkg::CountWidth-1:0]  i_max_retries,
    output lpc_pkg::t_lpc_status            o_status,
    output logic [lpc_pkg::ActionWidth-1:0] o_action
);
    import lpc_pkg::*;

    logic [CountWidth-1:0] bumped;
    logic                  keep_trying;

    // A disconnect counts once, saturating; attempts continue below the limit.
    assign bumped      = (i_status.retries != RetryCountMax) ?
                         i_status.retries + 8'd1 : i_status.retries;
    assign keep_trying = bumped < i_max_retries;

    always_comb begin
        o_status = i_status;
        o_action = ACT_NONE;
        case (i_status.link_state)
            ST_BOOT: begin
                if (i_event == EV_BOOT_SAVED) begin
                    o_status.saved      = 1'b1;
                    o_status.retries    = '0;
                    o_status.link_state = ST_CONN_SAVED;
                    o_action            = ACT_CONNECT;
                end else if (i_event == EV_BOOT_NOSAVED) begin
                    o_status.saved      = 1'b0;
                    o_status.link_state = ST_PROV;
                    o_action            = ACT_OPEN;
                end
            end
            ST_CONN_SAVED: begin
                if (i_event == EV_GOT_IP) begin
                    o_status.retries    = '0;
                    o_status.link_state = ST_ONLINE;
                    o_action            = ACT_CLOSE | ACT_ONLINE;
                end else if (i_event == EV_DISCONNECTED) begin
                    o_status.retries = bumped;
                    if (keep_trying) begin
                        o_action = ACT_CONNECT;
                    end else begin
                        o_status.link_state = ST_PROV;
                        o_action            = ACT_OPEN;
                    end
                end
            end
            ST_SAVED_FAIL: begin
                if (i_event == EV_RETRY) begin
                    o_status.retries    = '0;
                    o_status.link_state = ST_CONN_SAVED;
                    o_action            = ACT_CONNECT;
                end else if (i_event == EV_RECONFIGURE) begin
                    o_status.link_state = ST_PROV;
                    o_action            = ACT_OPEN;
                end
            end
            ST_PROV: begin
                if (i_event == EV_SUBMITTED) begin
                    o_status.candidate  = 1'b1;
                    o_status.retries    = '0;
                    o_status.link_state = ST_CONN_CAND;
                    o_action            = ACT_CONNECT;
                end else if (i_event == EV_PROV_FAIL && i_status.saved) begin
                    o_status.link_state = ST_ONLINE;
                    o_action            = ACT_CLOSE | ACT_ONLINE;
                end
            end
            ST_CONN_CAND: begin
                if (i_event == EV_CAND_IP || i_event == EV_GOT_IP) begin
                    o_status.link_state = ST_PERSIST;
                    o_action            = ACT_PERSIST;
                end else if (i_event == EV_DISCONNECTED) begin
                    o_status.retries = bumped;
                    if (keep_trying) begin
                        o_action = ACT_CONNECT;
                    end else begin
                        o_status.candidate = 1'b0;
                        if (i_status.saved) begin
                            o_status.link_state = ST_CONN_SAVED;
                            o_action            = ACT_RESTORE | ACT_CONNECT;
                        end else begin
                            o_status.link_state = ST_PROV;
                            o_action            = ACT_OPEN;
                        end
                    end
                end
            end
            ST_PERSIST: begin
                if (i_event == EV_COMMIT_OK) begin
                    o_status.link_state = ST_VERIFY;
                    o_action            = ACT_VERIFY;
                end else if (i_event == EV_COMMIT_FAIL) begin
                    o_status.link_state = ST_ROLLBACK;
                    o_action            = ACT_ROLLBACK;
                end
            end
            ST_VERIFY: begin
                if (i_event == EV_VERIFY_IP) begin
                    o_status.candidate  = 1'b0;
                    o_status.saved      = 1'b1;
                    o_status.retries    = '0;
                    o_status.link_state = ST_ONLINE;
                    o_action            = ACT_CLOSE | ACT_ONLINE;
                end else if (i_event == EV_DISCONNECTED || i_event == EV_VERIFY_FAIL) begin
                    o_status.link_state = ST_ROLLBACK;
                    o_action            = ACT_ROLLBACK;
                end
            end
            ST_ROLLBACK: begin
                if (i_event == EV_RB_OK) begin
                    o_status.candidate = 1'b0;
                    if (i_status.saved) begin
                        o_status.link_state = ST_CONN_SAVED;
                        o_action            = ACT_CONNECT;
                    end else begin
                        o_status.link_state = ST_PROV;
                        o_action            = ACT_OPEN;
                    end
                end else if (i_event == EV_RB_FAIL) begin
                    o_status.candidate  = 1'b0;
                    o_status.saved      = 1'b0;
                    o_status.link_state = ST_PROV;
                    o_action            = ACT_OPEN;
                end
            end
            ST_CAND_FAIL: begin
                if (i_event == EV_RETRY) begin
                    o_status.retries    = '0;
                    o_status.link_state = ST_CONN_CAND;
                    o_action            = ACT_CONNECT;
                end else if (i_event == EV_RECONFIGURE) begin
                    o_status.candidate  = 1'b0;
                    o_status.link_state = ST_PROV;
                    o_action            = i_status.saved ? (ACT_OPEN | ACT_RESTORE) : ACT_OPEN;
                end else if (i_event == EV_ABORTED) begin
                    o_status.candidate = 1'b0;
                    if (i_status.saved) begin
                        o_status.link_state = ST_CONN_SAVED;
                        o_action            = ACT_RESTORE | ACT_CONNECT;
                    end else begin
                        o_status.link_state = ST_PROV;
                        o_action            = ACT_OPEN;
                    end
                end
            end
            ST_ONLINE: begin
                if (i_event == EV_DISCONNECTED) begin
                    o_status.retries    = '0;
                    o_status.link_state = ST_CONN_SAVED;
                    o_action            = ACT_CONNECT;
                end else if (i_event == EV_RECONFIGURE) begin
                    o_status.link_state = ST_PROV;
                    o_action            = ACT_OPEN;
                end
            end
            default: begin
                o_status = i_status;
                o_action = ACT_NONE;
            end
        endcase
    end

endmodule

// ===== design/link_provisioning_controller.sv =====
// Link provisioning controller: connection and provisioning state machine, one event per transaction.
// The result of an accepted event is registered and appears on the outputs in the cycle after acceptance.
// Throughput: one event per cycle while not stalled; the status register and the next-status decode form the only loop.
// The input stalls only while a held result is itself stalled on the output side.
// Synchronous active-low reset returns to boot, clears counts and flags, sets max_retries to 5.
module link_provisioning_controller (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic [lpc_pkg::CountWidth-1:0]      i_cfg_wr_data,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [lpc_pkg::EventWidth-1:0]      i_event_code,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [lpc_pkg::ActionWidth-1:0]     o_action_mask,
    output logic [lpc_pkg::StateWidth-1:0]      o_state_now,
    output logic                                o_saved_present,
    output logic                                o_candidate_busy,
    output logic [lpc_pkg::CountWidth-1:0]      o_retries_seen
);
    import lpc_pkg::*;

    logic [CountWidth-1:0]  r_max_retries;
    t_lpc_status            r_status;
    t_lpc_status            n_status;
    logic [ActionWidth-1:0] n_action;
    logic                   r_out_valid;
    logic [ActionWidth-1:0] r_action;
    logic [StateWidth-1:0]  r_state_num;
    logic                   r_saved;
    logic                   r_candidate;
    logic [CountWidth-1:0]  r_retries;
    logic                   accept;

    assign o_stall = r_out_valid && i_stall;
    assign accept  = i_valid && !o_stall;

    lpc_next_state u_next_state (
        .i_status      (r_status),
        .i_event       (t_event'(i_event_code)),
        .i_max_retries (r_max_retries),
        .o_status      (n_status),
        .o_action      (n_action)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_retries <= MaxRetriesReset;
        end else if (i_cfg_wr_en) begin
            r_max_retries <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_status.link_state <= ST_BOOT;
            r_status.saved      <= 1'b0;
            r_status.candidate  <= 1'b0;
            r_status.retries    <= '0;
        end else if (accept) begin
            r_status <= n_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_action    <= n_action;
            r_state_num <= state_number(n_status.link_state);
            r_saved     <= n_status.saved;
            r_candidate <= n_status.candidate;
            r_retries   <= n_status.retries;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_action_mask    = r_action;
    assign o_state_now      = r_state_num;
    assign o_saved_present  = r_saved;
    assign o_candidate_busy = r_candidate;
    assign o_retries_seen   = r_retries;

`ifndef NO_ASSERTIONS
    // Every accepted event leaves a result waiting on the next cycle.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_valid)
        else $error("accepted transaction produced no result");

    // A result the output side stalls keeps its state number and retry count.
    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> ($stable(o_state_now) && $stable(o_retries_seen)))
        else $error("stalled result changed");

    // A candidate is never still marked busy once the link is online.
    a_online_no_candidate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_status.link_state == ST_ONLINE) |-> !r_status.candidate)
        else $error("candidate flag set while online");

    // The status moves only on an accepted transaction.
    a_status_only_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !accept |=> $stable(r_status))
        else $error("status changed without a transaction");
`endif

endmodule
